// ===== hw/rtl/utf8v_pkg.sv =====
// Shared types and constants for the UTF-8 stream validator.
// No dependencies; imported by every module of the block except utf8v_fifo.
package utf8v_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned REPORT_BITS     = 32;
  localparam int unsigned MID_DEPTH       = 2;
  localparam int unsigned OUT_DEPTH       = 2;

  // Lead bytes that restrict a later byte's range, and the second byte BF of EF BF xx
  localparam logic [7:0] LEAD_E0 = 8'he0;
  localparam logic [7:0] LEAD_ED = 8'hed;
  localparam logic [7:0] LEAD_EF = 8'hef;
  localparam logic [7:0] LEAD_F0 = 8'hf0;
  localparam logic [7:0] LEAD_F4 = 8'hf4;
  localparam logic [7:0] SECOND_BF = 8'hbf;

  // Continuation bytes still expected after a lead
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_ONE   = 2'd1;
  localparam logic [1:0] PEND_TWO   = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  // One byte after classification
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_ascii;   // 0x00..0x7f
    logic       is_nul;     // 0x00
    logic       is_cont;    // 10xxxxxx
    logic       lead_bad;   // non-ASCII byte that can never start a sequence
    logic [1:0] lead_pend;  // continuation bytes a good lead asks for
    logic       cont_80_9f; // 0x80..0x9f
    logic       cont_a0_bf; // 0xa0..0xbf
    logic       cont_80_8f; // 0x80..0x8f
    logic       cont_gt_8f; // above 0x8f
    logic       cont_be_bf; // 0xbe or 0xbf
  } byte_class_t;

  typedef struct packed {
    logic                   text_valid;
    logic [REPORT_BITS-1:0] error_offset;
  } result_t;

endpackage

// ===== hw/rtl/utf8v_fifo.sv =====
// Small register-based queue with full/empty flags.
// Depends on nothing; used between front and back and on the result side.
module utf8v_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/utf8v_front.sv =====
// Front end: decodes each incoming byte into class flags for the back end.
// Depends on utf8v_pkg.
module utf8v_front
  import utf8v_pkg::*;
(
  input  logic        [7:0] data_byte_i,
  input  logic              last_byte_i,
  output byte_class_t       class_o
);

  logic [7:0] b;

  assign b = data_byte_i;

  always_comb begin
    class_o            = '0;
    class_o.data       = b;
    class_o.last       = last_byte_i;
    class_o.is_ascii   = !b[7];
    class_o.is_nul     = (b == 8'h00);
    class_o.is_cont    = (b[7:6] == 2'b10);
    class_o.cont_80_9f = (b[7:5] == 3'b100);
    class_o.cont_a0_bf = (b[7:5] == 3'b101);
    class_o.cont_80_8f = (b[7:4] == 4'b1000);
    class_o.cont_gt_8f = (b > 8'h8f);
    class_o.cont_be_bf = (b[7:1] == 7'b1011111);
    // Leads: C2..DF take one, E0..EF two, F0..F4 three; all else non-ASCII is bad
    if (b[7:5] == 3'b110 && b[7:1] != 7'b1100000) begin
      class_o.lead_pend = PEND_ONE;
    end else if (b[7:4] == 4'b1110) begin
      class_o.lead_pend = PEND_TWO;
    end else if (b[7:3] == 5'b11110 && b <= LEAD_F4) begin
      class_o.lead_pend = PEND_THREE;
    end else begin
      class_o.lead_pend = PEND_NONE;
    end
    class_o.lead_bad = b[7] && (class_o.lead_pend == PEND_NONE);
  end

endmodule

// ===== hw/rtl/utf8v_back.sv =====
// Back end: sequence state, position counter and per-text verdict.
// Depends on utf8v_pkg; takes classified bytes from the middle queue.
module utf8v_back
  import utf8v_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  byte_class_t class_i,
  input  logic        class_valid_i,
  output logic        class_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output result_t     res_o
);

  logic [1:0]             pending_q, pending_d;
  logic [1:0]             len_q, len_d;       // pending count right after the lead
  logic [7:0]             lead_q, lead_d;
  logic [7:0]             second_q, second_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                   err_q, err_d;
  logic [OFFSET_BITS-1:0] err_pos_q, err_pos_d;
  logic                   stop_q, stop_d;

  logic                   take, bad, fin_err;
  logic [OFFSET_BITS-1:0] fin_pos;
  logic [REPORT_BITS-1:0] fin_report;

  assign take        = class_valid_i && !res_full_i;
  assign class_pop_o = take;
  assign res_push_o  = take && class_i.last;

  always_comb begin
    pending_d = pending_q;
    len_d     = len_q;
    lead_d    = lead_q;
    second_d  = second_q;
    start_d   = start_q;
    err_d     = err_q;
    err_pos_d = err_pos_q;
    stop_d    = stop_q;
    bad       = 1'b0;

    if (!err_q && !stop_q) begin
      if (pending_q == PEND_NONE) begin
        start_d  = pos_q;
        lead_d   = class_i.data;
        second_d = '0;
        len_d    = class_i.lead_pend;
        if (class_i.is_ascii) begin
          stop_d = class_i.is_nul;
        end else if (class_i.lead_bad) begin
          bad = 1'b1;
        end else begin
          pending_d = class_i.lead_pend;
        end
      end else begin
        bad = !class_i.is_cont;
        if (!bad && pending_q == len_q) begin
          // Second byte: reject overlongs, surrogates and values past U+10FFFF
          second_d = class_i.data;
          bad = (lead_q == LEAD_E0 && class_i.cont_80_9f) ||
                (lead_q == LEAD_ED && class_i.cont_a0_bf) ||
                (lead_q == LEAD_F0 && class_i.cont_80_8f) ||
                (lead_q == LEAD_F4 && class_i.cont_gt_8f);
        end else if (!bad && len_q == PEND_TWO && pending_q == PEND_ONE) begin
          // Final byte of EF BF xx: drop U+FFFE and U+FFFF
          bad = (lead_q == LEAD_EF) && (second_q == SECOND_BF) && class_i.cont_be_bf;
        end
        if (!bad) begin
          pending_d = pending_q - 1'b1;
        end
      end
      if (bad) begin
        err_d     = 1'b1;
        err_pos_d = start_d;
        pending_d = PEND_NONE;
      end
    end

    pos_d = (pos_q == '1) ? pos_q : pos_q + 1'b1;

    // End of text: an open sequence is a truncation error at its lead
    fin_err = err_d;
    fin_pos = err_pos_d;
    if (!err_d && !stop_d && pending_d != PEND_NONE) begin
      fin_err = 1'b1;
      fin_pos = start_d;
    end
  end

  if (OFFSET_BITS > REPORT_BITS) begin : g_sat
    assign fin_report = (fin_pos[OFFSET_BITS-1:REPORT_BITS] != '0) ? '1
                                                : fin_pos[REPORT_BITS-1:0];
  end else begin : g_ext
    assign fin_report = REPORT_BITS'(fin_pos);
  end

  assign res_o.text_valid   = !fin_err;
  assign res_o.error_offset = fin_err ? fin_report : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= PEND_NONE;
      len_q     <= PEND_NONE;
      lead_q    <= '0;
      second_q  <= '0;
      pos_q     <= '0;
      start_q   <= '0;
      err_q     <= 1'b0;
      err_pos_q <= '0;
      stop_q    <= 1'b0;
    end else if (take) begin
      if (class_i.last) begin
        pending_q <= PEND_NONE;
        len_q     <= PEND_NONE;
        lead_q    <= '0;
        second_q  <= '0;
        pos_q     <= '0;
        start_q   <= '0;
        err_q     <= 1'b0;
        err_pos_q <= '0;
        stop_q    <= 1'b0;
      end else begin
        pending_q <= pending_d;
        len_q     <= len_d;
        lead_q    <= lead_d;
        second_q  <= second_d;
        pos_q     <= pos_d;
        start_q   <= start_d;
        err_q     <= err_d;
        err_pos_q <= err_pos_d;
        stop_q    <= stop_d;
      end
    end
  end

  a_pend_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= len_q)
    else $error("pending count exceeds sequence length");

  a_err_closes_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q || stop_q) |-> (pending_q == PEND_NONE))
    else $error("sequence still open after error or stop");

  a_restart_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (pos_q == '0 && !err_q && !stop_q))
    else $error("state not cleared after result");

  a_start_behind_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q <= pos_q)
    else $error("sequence start ahead of position");

endmodule

// ===== hw/rtl/utf8_stream_validator.sv =====
// Top level of the strict UTF-8 stream validator.
// Depends on utf8v_pkg, utf8v_front, utf8v_back and utf8v_fifo.
//
// Feed a text one byte per transaction on the push side, marking its final
// byte with last_byte_i. Each byte is checked for strict UTF-8: bad lead or
// continuation bytes, overlong forms, surrogates, U+FFFE/U+FFFF and code
// points above U+10FFFF are errors, and so is a sequence cut off by the last
// byte. A NUL in lead position ends checking for the rest of that text. Only
// the last byte yields a result transaction: text_valid_o, and error_offset_o
// holding the offset of the lead byte of the first bad sequence (0 if valid,
// saturated at 2^32-1). The next byte then starts a new text at offset 0.
// The block takes one byte per clock as long as the result side is popped;
// the back end updates the sequence state for each byte that it takes. A byte
// passes through the two-entry queue between front and back, and its verdict
// through the two-entry result queue, before the result is visible.
// OFFSET_BITS sets the width of the internal saturating byte counter.
module utf8_stream_validator
  import utf8v_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output logic                   empty,
  input  logic                   pop,
  output logic                   text_valid_o,
  output logic [REPORT_BITS-1:0] error_offset_o
);

  byte_class_t front_class, back_class;
  logic        mid_empty, mid_pop;
  logic        res_full, res_push;
  result_t     res_in, res_out;

  // Front: classify the byte as it arrives
  utf8v_front u_front (
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .class_o     (front_class)
  );

  // Decouple intake from the sequence checker
  utf8v_fifo #(
    .WIDTH ($bits(byte_class_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_class),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (back_class),
    .empty_o (mid_empty)
  );

  // Back: advance the sequence state, emit a verdict on the last byte
  utf8v_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .class_i       (back_class),
    .class_valid_i (!mid_empty),
    .class_pop_o   (mid_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  // Hold verdicts until the consumer pops them
  utf8v_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign text_valid_o   = res_out.text_valid;
  assign error_offset_o = res_out.error_offset;

endmodule

// ===== sim/utf8v_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the UTF-8 stream validator: watches both queue ports,
// predicts the verdict of each text and compares it. Depends on utf8v_pkg.
module utf8v_checker
  import utf8v_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic                   full_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  input  logic                   empty_i,
  input  logic                   pop_i,
  input  logic                   text_valid_i,
  input  logic [REPORT_BITS-1:0] error_offset_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            open_reports_o
);

  // Sequence state of the text being scanned
  logic [1:0]             pend;
  logic [7:0]             lead_b;
  logic [7:0]             second_b;
  logic [REPORT_BITS-1:0] byte_pos;
  logic [REPORT_BITS-1:0] seq_begin;
  logic [REPORT_BITS-1:0] err_pos;
  logic                   err_seen;
  logic                   halted;

  result_t expected_reports[$];
  result_t want;

  task automatic clear_scan();
    pend      = PEND_NONE;
    lead_b    = 8'h00;
    second_b  = 8'h00;
    byte_pos  = '0;
    seq_begin = '0;
    err_pos   = '0;
    err_seen  = 1'b0;
    halted    = 1'b0;
  endtask

  task automatic raise_error();
    err_seen = 1'b1;
    err_pos  = seq_begin;
    pend     = PEND_NONE;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic is_last);
    int      seq_len;
    logic    bad;
    result_t verdict;
    if (!err_seen && !halted) begin
      if (pend == PEND_NONE) begin
        seq_begin = byte_pos;
        lead_b    = b;
        second_b  = 8'h00;
        if (!b[7]) begin
          if (b == 8'h00) halted = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          if (b[7:1] == 7'b1100000) raise_error();
          else pend = PEND_ONE;
        end else if (b[7:4] == 4'b1110) begin
          pend = PEND_TWO;
        end else if (b[7:3] == 5'b11110) begin
          if (b > LEAD_F4) raise_error();
          else pend = PEND_THREE;
        end else begin
          raise_error();
        end
      end else begin
        if (lead_b[7:5] == 3'b110) seq_len = 2;
        else if (lead_b[7:4] == 4'b1110) seq_len = 3;
        else seq_len = 4;
        bad = (b[7:6] != 2'b10);
        if (!bad && int'(pend) == seq_len - 1) begin
          second_b = b;
          // overlong, surrogate and above-range forms show in the second byte
          if ((lead_b == LEAD_E0 && b[7:5] == 3'b100) ||
              (lead_b == LEAD_ED && b[7:5] == 3'b101) ||
              (lead_b == LEAD_F0 && b[7:4] == 4'b1000) ||
              (lead_b == LEAD_F4 && b > 8'h8f))
            bad = 1'b1;
        end else if (!bad && seq_len == 3 && pend == PEND_ONE) begin
          // U+FFFE and U+FFFF
          if (lead_b == LEAD_EF && second_b == SECOND_BF && b[7:1] == 7'b1011111)
            bad = 1'b1;
        end
        if (bad) raise_error();
        else pend = pend - 2'd1;
      end
    end
    if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
    if (is_last) begin
      if (!err_seen && !halted && pend != PEND_NONE) raise_error();
      verdict.text_valid   = !err_seen;
      verdict.error_offset = err_seen ? err_pos : '0;
      expected_reports = {expected_reports, verdict};
      clear_scan();
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count_o = mismatch_count_o + 1;
    if (mismatch_count_o <= 10) $display("%t utf8v_checker: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_reports.delete();
      mismatch_count_o = 0;
      open_reports_o   = 0;
    end else begin
      if (push_i && !full_i) scan_byte(data_byte_i, last_byte_i);
      if (pop_i && !empty_i) begin
        if (expected_reports.size() == 0) begin
          note_mismatch($sformatf("unexpected result valid=%0b offset=%0d",
                                  text_valid_i, error_offset_i));
        end else begin
          want = expected_reports.pop_front();
          if (text_valid_i !== want.text_valid || error_offset_i !== want.error_offset)
            note_mismatch($sformatf("expected valid=%0b offset=%0d, got valid=%0b offset=%0d",
                                    want.text_valid, want.error_offset,
                                    text_valid_i, error_offset_i));
        end
      end
      open_reports_o = expected_reports.size();
    end
  end

endmodule

// ===== sim/tb_utf8_stream_validator.sv =====
`timescale 1ns / 100ps
// Testbench top for utf8_stream_validator: drives texts byte by byte and pops
// verdicts. Depends on utf8v_pkg, the validator RTL and utf8v_checker.
module tb_utf8_stream_validator;
  import utf8v_pkg::*;

  localparam int LIMIT_NS     = 500_000;  // far beyond the slowest correct run
  localparam int RANDOM_BYTES = 330;
  localparam int LONG_HOLD    = 300;      // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = 20;

  // Boundary bytes for corrupting otherwise well-formed texts
  localparam logic [7:0] CORNER_BYTES [0:19] = '{
    8'h00, 8'h7f, 8'h80, 8'h8f, 8'h90, 8'h9f, 8'ha0, 8'hbe, 8'hbf, 8'hc0,
    8'hc1, 8'hc2, 8'hdf, 8'he0, 8'hed, 8'hef, 8'hf0, 8'hf4, 8'hf5, 8'hff
  };

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   push      = 1'b0;
  logic [7:0]             data_byte = 8'h00;
  logic                   last_byte = 1'b0;
  logic                   pop       = 1'b0;
  logic                   full;
  logic                   empty;
  logic                   text_valid;
  logic [REPORT_BITS-1:0] error_offset;

  int unsigned mismatch_count;
  int unsigned open_reports;

  // Handshake shaping: no_idle for the sender and receiver, long_hold for the receiver
  bit no_idle   = 1'b0;
  bit long_hold = 1'b0;

  logic [7:0] text_buf[$];
  int         random_bytes_sent;
  int         text_idx;
  int         rx_gap;

  always #1 clk_i = ~clk_i;

  utf8_stream_validator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte),
    .last_byte_i   (last_byte),
    .empty         (empty),
    .pop           (pop),
    .text_valid_o  (text_valid),
    .error_offset_o(error_offset)
  );

  utf8v_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .empty_i         (empty),
    .pop_i           (pop),
    .text_valid_i    (text_valid),
    .error_offset_i  (error_offset),
    .mismatch_count_o(mismatch_count),
    .open_reports_o  (open_reports)
  );

  // Mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Add one byte at the end of the text buffer
  task automatic append_byte(input logic [7:0] b);
    text_buf = {text_buf, b};
  endtask

  // Offer one byte after a random gap and hold it until the transaction
  // completes. Keep push high across back-to-back bytes.
  task automatic offer_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    do @(posedge clk_i); while (full);
  endtask

  // Send the buffered text, marking its final byte, then drop the buffer.
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      offer_byte(text_buf[i], i == text_buf.size() - 1);
    random_bytes_sent = random_bytes_sent + text_buf.size();
    text_buf.delete();
  endtask

  // Append one well-formed sequence with random content; favor the leads
  // that narrow the second byte so the range edges get exercised.
  task automatic add_good_sequence();
    int         kind;
    logic [7:0] lead;
    logic [7:0] c1;
    logic [7:0] lo;
    logic [7:0] hi;
    kind = $urandom_range(0, 9);
    lo   = 8'h80;
    hi   = 8'hbf;
    if (kind < 4) begin
      // occasional NUL: ends checking for the rest of the text
      if ($urandom_range(0, 39) == 0) append_byte(8'h00);
      else append_byte(8'($urandom_range(1, 127)));
    end else if (kind < 6) begin
      append_byte(8'($urandom_range(8'hc2, 8'hdf)));
      append_byte(8'($urandom_range(8'h80, 8'hbf)));
    end else if (kind < 8) begin
      case ($urandom_range(0, 5))
        0: lead = LEAD_E0;
        1: lead = LEAD_ED;
        2: lead = LEAD_EF;
        default: lead = 8'($urandom_range(8'he0, 8'hef));
      endcase
      if (lead == LEAD_E0) lo = 8'ha0;
      if (lead == LEAD_ED) hi = 8'h9f;
      c1 = 8'($urandom_range(lo, hi));
      append_byte(lead);
      append_byte(c1);
      // keep clear of U+FFFE and U+FFFF
      if (lead == LEAD_EF && c1 == SECOND_BF)
        append_byte(8'($urandom_range(8'h80, 8'hbd)));
      else
        append_byte(8'($urandom_range(8'h80, 8'hbf)));
    end else begin
      case ($urandom_range(0, 5))
        0: lead = LEAD_F0;
        1: lead = LEAD_F4;
        default: lead = 8'($urandom_range(8'hf0, 8'hf4));
      endcase
      if (lead == LEAD_F0) lo = 8'h90;
      if (lead == LEAD_F4) hi = 8'h8f;
      append_byte(lead);
      append_byte(8'($urandom_range(lo, hi)));
      append_byte(8'($urandom_range(8'h80, 8'hbf)));
      append_byte(8'($urandom_range(8'h80, 8'hbf)));
    end
  endtask

  // Build a text of one to five sequences; corrupt about a third of the texts.
  task automatic build_random_text();
    int n_seq;
    int r;
    int pos;
    n_seq = $urandom_range(1, 5);
    repeat (n_seq) add_good_sequence();
    r   = $urandom_range(0, 99);
    pos = $urandom_range(0, text_buf.size() - 1);
    if (r < 15) begin
      text_buf[pos] = 8'($urandom_range(0, 255));
    end else if (r < 25) begin
      text_buf[pos] = CORNER_BYTES[$urandom_range(0, 19)];
    end else if (r < 32) begin
      // cut the text short, often inside a sequence
      if (text_buf.size() > 1) text_buf.delete(text_buf.size() - 1);
    end else if (r < 36) begin
      repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: pop in bursts between random gaps; on request hold off for a
  // long stretch so the block backs up and stalls its input.
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        rx_gap = pick_gap();
        if (rx_gap > 0) begin
          pop <= 1'b0;
          repeat (rx_gap) @(posedge clk_i);
        end
        pop <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_utf8_stream_validator: done, errors");
    $finish;
  end

  initial begin
    random_bytes_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed texts: plain ASCII, NUL terminator, rejected forms, truncation,
    // a bad lead, a lone continuation, NUL as continuation, a good 4-byte form.
    text_buf = '{8'h41};                      send_text();
    text_buf = '{8'h00};                      send_text();
    text_buf = '{8'hc0, 8'h80};               send_text();
    text_buf = '{8'he0, 8'h80, 8'h80};        send_text();
    text_buf = '{8'hed, 8'ha0, 8'h80};        send_text();
    text_buf = '{8'hef, 8'hbf, 8'hbf};        send_text();
    text_buf = '{8'hf4, 8'h90, 8'h80, 8'h80}; send_text();
    text_buf = '{8'h41, 8'he2};               send_text();
    text_buf = '{8'hff};                      send_text();
    text_buf = '{8'h7f, 8'h80};               send_text();
    text_buf = '{8'h00, 8'hff};               send_text();
    text_buf = '{8'hc3, 8'h00};               send_text();
    text_buf = '{8'hf0, 8'h9f, 8'h98, 8'h80}; send_text();

    // Back-pressure: stall the receiver while one-byte texts pour in, so
    // both internal queues fill and full rises.
    long_hold = 1'b1;
    no_idle   = 1'b1;
    repeat (40) begin
      append_byte(8'($urandom_range(1, 255)));
      send_text();
    end
    no_idle = 1'b0;

    // Random texts, with one stretch where neither side idles
    random_bytes_sent = 0;
    text_idx          = 0;
    while (random_bytes_sent < RANDOM_BYTES) begin
      no_idle = (text_idx >= 25 && text_idx < 35);
      build_random_text();
      send_text();
      text_idx = text_idx + 1;
    end
    no_idle = 1'b0;
    push <= 1'b0;

    // Let the last transaction reach the checker, then drain the verdicts.
    @(posedge clk_i);
    while (open_reports != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && open_reports == 0)
      $display("tb_utf8_stream_validator: done, clean");
    else
      $display("tb_utf8_stream_validator: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/utf8v_pkg.sv
hw/rtl/utf8v_fifo.sv
hw/rtl/utf8v_front.sv
hw/rtl/utf8v_back.sv
hw/rtl/utf8_stream_validator.sv
sim/utf8v_checker.sv
sim/tb_utf8_stream_validator.sv
